### hw/rtl/bpa_pkg.sv
package bpa_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   localparam int ADDR_W    = 10;
   localparam int MAP_WORDS = 1024;
   localparam int PAGE_W    = 16;
   localparam int CNT_W     = 17;

   localparam logic [CNT_W-1:0]  MAX_PAGES = 17'd65536;
   localparam logic [ADDR_W-1:0] LAST_MAP_WORD = 10'(MAP_WORDS - 1);

   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_FREE    = 2'd1;
   localparam logic [1:0] FUNC_RESERVE = 2'd2;
   localparam logic [1:0] FUNC_NONE    = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   localparam logic [2:0] REG_PAGE_TOTAL = 3'd0;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN1,
      S_SCAN2,
      S_WPREP,
      S_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear_step;
      logic       scan_init;
      logic       scan_pass2;
      logic       scan_step;
      logic       write_init;
      logic       write_step;
      logic       finish;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_bad;
      logic is_alloc;
      logic skip_pass1;
      logic skip_pass2;
      logic scan_hit;
      logic scan_miss;
      logic write_last;
      logic out_busy;
   } sts_type;

   function automatic logic [WORD_BITS-1:0] ones_from(input logic [BIT_W-1:0] idx);
      return {WORD_BITS{1'b1}} << idx;
   endfunction

   function automatic logic [WORD_BITS-1:0] ones_upto(input logic [BIT_W-1:0] idx);
      return {WORD_BITS{1'b1}} >> (6'd63 - idx);
   endfunction

endpackage

### hw/rtl/bpa_ctrl.sv
module bpa_ctrl import bpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (sts.req_bad) begin
               code_in  = ST_BAD;
               state_in = S_DONE;
            end else if (!sts.is_alloc) begin
               cmd.write_init = 1'b1;
               state_in       = S_WRITE;
            end else if (!sts.skip_pass1) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN1;
            end else if (!sts.skip_pass2) begin
               cmd.scan_init  = 1'b1;
               cmd.scan_pass2 = 1'b1;
               state_in       = S_SCAN2;
            end else begin
               code_in  = ST_NOFIT;
               state_in = S_DONE;
            end
         end
         S_SCAN1: begin
            cmd.scan_step = 1'b1;
            priority if (sts.scan_hit) begin
               state_in = S_WPREP;
            end else if (sts.scan_miss && !sts.skip_pass2) begin
               cmd.scan_init  = 1'b1;
               cmd.scan_pass2 = 1'b1;
               state_in       = S_SCAN2;
            end else if (sts.scan_miss) begin
               code_in  = ST_NOFIT;
               state_in = S_DONE;
            end
         end
         S_SCAN2: begin
            cmd.scan_step = 1'b1;
            priority if (sts.scan_hit) begin
               state_in = S_WPREP;
            end else if (sts.scan_miss) begin
               code_in  = ST_NOFIT;
               state_in = S_DONE;
            end
         end
         S_WPREP: begin
            cmd.write_init = 1'b1;
            state_in       = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_step = 1'b1;
            if (sts.write_last) begin
               code_in  = ST_DONE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_CHECK)
      else $error("accepted word did not move to the check state");

   a_hit_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN1 || state_ff == S_SCAN2) && sts.scan_hit)
      |=> state_ff == S_WPREP)
      else $error("found run was not written");

   a_write_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && !sts.write_last) |=> state_ff == S_WRITE)
      else $error("range write left early");

endmodule

### hw/rtl/bpa_dp.sv
module bpa_dp import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [1:0]        req_func,
   input  logic [PAGE_W-1:0] req_first_page,
   input  logic [CNT_W-1:0]  req_page_count,
   input  logic [CNT_W-1:0]  page_total,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [PAGE_W-1:0] rsp_run_start,
   output logic [CNT_W-1:0]  rsp_free_count
);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa;
   logic [WORD_BITS-1:0] mem_wd;

   logic [ADDR_W-1:0] clr_addr_ff;
   logic [1:0]        func_ff;
   logic [PAGE_W-1:0] first_ff;
   logic [CNT_W-1:0]  count_ff, total_ff;
   logic [CNT_W-1:0]  search_start_ff, free_ff;
   logic [ADDR_W-1:0] issue_ff, paddr_ff;
   logic              pvalid_ff, pass2_ff;
   logic [CNT_W-1:0]  carry_len_ff;
   logic [PAGE_W-1:0] carry_start_ff, at_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [PAGE_W-1:0] rsp_run_start_ff;
   logic [CNT_W-1:0]  rsp_free_ff;

   logic [CNT_W-1:0]  last_start, total_m1, wend_full;
   logic [CNT_W:0]    range_end;
   logic              is_alloc, set_bits;
   logic [PAGE_W-1:0] wlo, wend, base;
   logic [ADDR_W-1:0] last_word;

   logic [WORD_BITS-1:0] free_w, nfree, acc, wmask, chg, new_word;
   logic [WORD_BITS-1:0] pw [7];
   logic [6:0]           count7, t1, lead, pc;
   logic [BIT_W-1:0]     low_zero, high_zero, b_idx;
   logic                 all_free, b_hit, a_hit, found, late;
   logic [CNT_W:0]       a_sum;
   logic [PAGE_W-1:0]    eff_cstart, found_at, new_cstart;
   logic [CNT_W-1:0]     new_clen;

   always_comb begin
      is_alloc   = func_ff == FUNC_ALLOC;
      set_bits   = func_ff != FUNC_FREE;
      last_start = total_ff - count_ff;
      total_m1   = total_ff - 17'd1;
      last_word  = total_m1[PAGE_W-1:BIT_W];
      range_end  = {2'b0, first_ff} + {1'b0, count_ff};
      wlo        = is_alloc ? at_ff : first_ff;
      wend_full  = {1'b0, wlo} + count_ff - 17'd1;
      wend       = wend_full[PAGE_W-1:0];
      base       = {paddr_ff, {BIT_W{1'b0}}};
   end

   // Word scan: free pages in range, runs across and inside the word.
   always_comb begin
      free_w = ~rd_data_ff;
      if (!pass2_ff && paddr_ff == search_start_ff[PAGE_W-1:BIT_W])
         free_w = free_w & ones_from(search_start_ff[BIT_W-1:0]);
      if (paddr_ff == last_word)
         free_w = free_w & ones_upto(total_m1[BIT_W-1:0]);
      nfree    = ~free_w;
      all_free = free_w == {WORD_BITS{1'b1}};

      low_zero  = '0;
      high_zero = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (nfree[i]) low_zero = BIT_W'(i);
      end
      for (int i = 0; i < WORD_BITS; i++) begin
         if (nfree[i]) high_zero = BIT_W'(i);
      end
      t1   = all_free ? 7'd64 : {1'b0, low_zero};
      lead = all_free ? 7'd64 : 7'd63 - {1'b0, high_zero};

      count7 = count_ff[6:0];
      pw[0]  = free_w;
      for (int k = 1; k < 7; k++) begin
         pw[k] = pw[k-1] & (pw[k-1] >> (1 << (k - 1)));
      end
      acc = {WORD_BITS{1'b1}};
      for (int k = 0; k < 7; k++) begin
         if (count7[k]) acc = acc & (pw[k] >> (count7 & 7'((1 << k) - 1)));
      end
      b_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (acc[i]) b_idx = BIT_W'(i);
      end
      b_hit = (count_ff <= 17'd64) && (acc != '0);

      eff_cstart = (carry_len_ff != '0) ? carry_start_ff : base;
      a_sum      = {1'b0, carry_len_ff} + {11'b0, t1};
      a_hit      = a_sum >= {1'b0, count_ff};
      found      = a_hit || b_hit;
      found_at   = a_hit ? eff_cstart : (base + {10'b0, b_idx});
      late       = pass2_ff && ({1'b0, found_at} >= search_start_ff);

      if (all_free) begin
         new_clen   = carry_len_ff + 17'd64;
         new_cstart = eff_cstart;
      end else begin
         new_clen   = {10'b0, lead};
         new_cstart = base + (16'd64 - {9'b0, lead});
      end
   end

   // Range write: mask, changed bits and their count.
   always_comb begin
      wmask = {WORD_BITS{1'b1}};
      if (paddr_ff == wlo[PAGE_W-1:BIT_W]) wmask = wmask & ones_from(wlo[BIT_W-1:0]);
      if (paddr_ff == wend[PAGE_W-1:BIT_W]) wmask = wmask & ones_upto(wend[BIT_W-1:0]);
      chg      = set_bits ? (wmask & ~rd_data_ff) : (wmask & rd_data_ff);
      new_word = set_bits ? (rd_data_ff | wmask) : (rd_data_ff & ~wmask);
      pc       = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         pc = pc + 7'(chg[i]);
      end
   end

   always_comb begin
      mem_we = cmd.clear_step || (cmd.write_step && pvalid_ff);
      mem_wa = cmd.clear_step ? clr_addr_ff : paddr_ff;
      mem_wd = cmd.clear_step ? {WORD_BITS{1'b1}} : new_word;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[issue_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff     <= '0;
         search_start_ff <= '0;
         free_ff         <= '0;
         pvalid_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + 10'd1;
         if (cmd.scan_init || cmd.write_init) begin
            pvalid_ff <= 1'b0;
         end else if (cmd.scan_step || cmd.write_step) begin
            pvalid_ff <= 1'b1;
         end
         if (cmd.write_init && is_alloc) search_start_ff <= {1'b0, at_ff} + count_ff;
         if (cmd.write_step && pvalid_ff) begin
            free_ff <= set_bits ? free_ff - {10'b0, pc} : free_ff + {10'b0, pc};
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         first_ff <= req_first_page;
         count_ff <= req_page_count;
         total_ff <= (page_total > MAX_PAGES) ? MAX_PAGES : page_total;
      end
      if (cmd.scan_init) begin
         issue_ff     <= cmd.scan_pass2 ? '0 : search_start_ff[PAGE_W-1:BIT_W];
         pass2_ff     <= cmd.scan_pass2;
         carry_len_ff <= '0;
      end else if (cmd.write_init) begin
         issue_ff <= wlo[PAGE_W-1:BIT_W];
      end else if (cmd.scan_step || cmd.write_step) begin
         issue_ff <= issue_ff + 10'd1;
         paddr_ff <= issue_ff;
      end
      if (cmd.scan_step && pvalid_ff && !cmd.scan_init) begin
         carry_len_ff   <= new_clen;
         carry_start_ff <= new_cstart;
         if (found) at_ff <= found_at;
      end
      if (cmd.finish) begin
         rsp_status_ff    <= cmd.code;
         rsp_run_start_ff <= (cmd.code == ST_DONE && is_alloc) ? at_ff : '0;
         rsp_free_ff      <= free_ff;
      end
   end

   always_comb begin
      sts.clear_last = clr_addr_ff == LAST_MAP_WORD;
      sts.req_bad    = (func_ff == FUNC_NONE) || (count_ff == '0) ||
                       (is_alloc ? (count_ff > total_ff)
                                 : (range_end > {1'b0, total_ff}));
      sts.is_alloc   = is_alloc;
      sts.skip_pass1 = search_start_ff > last_start;
      sts.skip_pass2 = search_start_ff == '0;
      sts.scan_hit   = pvalid_ff && found && !late;
      sts.scan_miss  = pvalid_ff && ((found && late) || (!found && paddr_ff == last_word));
      sts.write_last = pvalid_ff && paddr_ff == wend[PAGE_W-1:BIT_W];
      sts.out_busy   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_run_start  = rsp_run_start_ff;
   assign rsp_free_count = rsp_free_ff;

   a_free_stable: assert property (@(posedge clock) disable iff (reset)
      !cmd.write_step |=> $stable(free_ff))
      else $error("free count moved outside a range write");

   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result word appeared without a finish");

   a_init_flush: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_init || cmd.write_init) |=> !pvalid_ff)
      else $error("stale map word survived a pass start");

endmodule

### hw/rtl/bitmap_page_allocator.sv
// An allocate scans the page map one 64-bit map word at a time and wraps to page zero for a
// second pass when the search did not start there and no run was found; it then writes the
// map words of the found run. Free and reserve write the map words of their range, and a
// rejected request writes nothing.
// One request is in work at a time, bound by the single read port of the page map.
// After reset the map is set to all used by a pass over all 1024 map words, during which no
// request word is taken; the page total register resets to 65536.
module bitmap_page_allocator import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [PAGE_W-1:0] req_first_page,
   input  logic [CNT_W-1:0]  req_page_count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [PAGE_W-1:0] rsp_run_start,
   output logic [CNT_W-1:0]  rsp_free_count,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [CNT_W-1:0] page_total_ff;
   cmd_type          cmd;
   sts_type          sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_total_ff <= MAX_PAGES;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_PAGE_TOTAL) begin
         page_total_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_PAGE_TOTAL) ? {15'b0, page_total_ff} : '0;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_first_page (req_first_page),
      .req_page_count (req_page_count),
      .page_total     (page_total_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_run_start  (rsp_run_start),
      .rsp_free_count (rsp_free_count)
   );

endmodule
